### hw/rtl/dcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, register indexes and reset values for the colour shifter.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int WL_W   = 10;              // wavelength register width
  localparam int COL_W  = 16;              // Q4.12 colour width
  localparam int FAC_W  = 24;              // Q8.16 factor width
  localparam int POS_W  = WL_W + FAC_W;    // position, 2^-16 nm units
  localparam int KPOS_W = WL_W + 16;       // knot position width
  localparam int VAL_W  = COL_W + 3;       // knot value in eighths
  localparam int PRD_W  = VAL_W + KPOS_W;  // one interpolation product
  localparam int NUM_W  = PRD_W + 2;       // dividend
  localparam int DEN_W  = POS_W + 3;       // divisor (8 * d)
  localparam int QB     = 17;              // quotient bits (quotient < 2^17)
  localparam int REM_W  = DEN_W + QB;      // working remainder width
  localparam int IDX_W  = 3;

  localparam logic [FAC_W-1:0] UNIT_FACTOR = FAC_W'(65536);
  localparam logic [COL_W-1:0] MAX_COL     = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_UV    = 3'd0,
    REG_BLUE  = 3'd1,
    REG_GREEN = 3'd2,
    REG_RED   = 3'd3,
    REG_IR    = 3'd4
  } reg_idx_t;

  localparam logic [WL_W-1:0] RST_UV    = 10'd380;
  localparam logic [WL_W-1:0] RST_BLUE  = 10'd450;
  localparam logic [WL_W-1:0] RST_GREEN = 10'd530;
  localparam logic [WL_W-1:0] RST_RED   = 10'd650;
  localparam logic [WL_W-1:0] RST_IR    = 10'd780;

endpackage

### hw/rtl/dcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_in_if / dcs_out_if
// Valid/ready channels carrying one colour request and one shifted colour.
// ----------------------------------------------------------------------------
interface dcs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] shift_factor;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] filter_in;
  logic [15:0] transmit_in;

  modport source (output valid, mode, shift_factor, red_in, green_in, blue_in,
                  filter_in, transmit_in, input ready);
  modport sink   (input valid, mode, shift_factor, red_in, green_in, blue_in,
                  filter_in, transmit_in, output ready);
endinterface

interface dcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] filter_out;
  logic [15:0] transmit_out;

  modport source (output valid, red_out, green_out, blue_out, filter_out,
                  transmit_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, filter_out,
                  transmit_out, output ready);
endinterface

### hw/rtl/doppler_colour_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_colour_shift
// Doppler shift of one colour per cycle, when not stalled, through a 22-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled and returns one shifted
// colour per request, in order. Red, green and blue each sample a
// spectrum at their own wavelength times shift_factor (piecewise linear, with
// a 1/p infrared wing in falloff mode); filter and transmit are copied. The
// stages are: position multiply, segment select, interpolation multiply,
// dividend sum, then a 17-stage restoring divider (one quotient bit a stage)
// and the saturating output register. The whole pipe advances on one enable,
// held off only when the output register is full and not taken, so a stall
// loses and repeats nothing. Wavelength registers are written through
// cfg_we/cfg_idx/cfg_data and must only change while the pipe is empty.
// ----------------------------------------------------------------------------
module doppler_colour_shift
  import dcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [WL_W-1:0]  cfg_data,
  dcs_in_if.sink           in_ch,
  dcs_out_if.source        out_ch
);

  localparam int NSTG = 4 + QB + 1;

  typedef struct packed {
    logic              byp;
    logic [COL_W-1:0]  bval;
    logic [VAL_W-1:0]  a8;
    logic [KPOS_W-1:0] m1;
    logic [VAL_W-1:0]  b8;
    logic [KPOS_W-1:0] m2;
    logic [POS_W-1:0]  d;
  } seg_t;

  // wavelength registers
  logic [WL_W-1:0] wl_uv, wl_b, wl_g, wl_r, wl_ir;

  always_ff @(posedge clk) begin
    if (rst) begin
      wl_uv <= RST_UV;
      wl_b  <= RST_BLUE;
      wl_g  <= RST_GREEN;
      wl_r  <= RST_RED;
      wl_ir <= RST_IR;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_UV:    wl_uv <= cfg_data;
        REG_BLUE:  wl_b  <= cfg_data;
        REG_GREEN: wl_g  <= cfg_data;
        REG_RED:   wl_r  <= cfg_data;
        REG_IR:    wl_ir <= cfg_data;
        default:   ;
      endcase
    end
  end

  // pipeline enable: advance unless the output holds an untaken result
  logic            en;
  logic [NSTG-1:0] vld;

  assign en          = !vld[NSTG-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_ch.valid};
    end
  end

  // filter/transmit ride alongside
  logic [2*COL_W-1:0] ft_pipe [NSTG];

  always_ff @(posedge clk) begin
    if (en) begin
      ft_pipe[0] <= {in_ch.filter_in, in_ch.transmit_in};
      for (int k = 1; k < NSTG; k++) begin
        ft_pipe[k] <= ft_pipe[k-1];
      end
    end
  end

  // stage 1: position p = w * f per channel (0 red, 1 green, 2 blue)
  logic [FAC_W-1:0] fac;
  logic [POS_W-1:0] s1_p   [3];
  logic [COL_W-1:0] s1_col [3];
  logic             s1_mode, s1_unit;

  assign fac = (in_ch.shift_factor == '0) ? FAC_W'(1) : in_ch.shift_factor;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p[0]   <= POS_W'(wl_r) * POS_W'(fac);
      s1_p[1]   <= POS_W'(wl_g) * POS_W'(fac);
      s1_p[2]   <= POS_W'(wl_b) * POS_W'(fac);
      s1_col[0] <= in_ch.red_in;
      s1_col[1] <= in_ch.green_in;
      s1_col[2] <= in_ch.blue_in;
      s1_mode   <= in_ch.mode;
      s1_unit   <= (fac == UNIT_FACTOR);
    end
  end

  // segment for one interpolation between knots
  function automatic seg_t mk_seg(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                  logic [POS_W-1:0] p, logic [KPOS_W-1:0] lo,
                                  logic [KPOS_W-1:0] hi);
    seg_t             s;
    logic [KPOS_W-1:0] num, den;
    num    = KPOS_W'(p - POS_W'(lo));
    den    = hi - lo;
    s.byp  = 1'b0;
    s.bval = '0;
    s.a8   = a;
    s.b8   = b;
    s.m1   = den - num;
    s.m2   = num;
    s.d    = POS_W'(den);
    return s;
  endfunction

  function automatic seg_t mk_byp(logic [COL_W-1:0] v);
    seg_t s;
    s      = '0;
    s.byp  = 1'b1;
    s.bval = v;
    return s;
  endfunction

  // stage 2: pick the spectrum segment
  logic [KPOS_W-1:0] kp [5];
  logic [VAL_W-1:0]  kv [5];
  seg_t              sel  [3];
  seg_t              s2   [3];

  always_comb begin
    kp[0] = {wl_uv, 16'b0};
    kp[1] = {wl_b,  16'b0};
    kp[2] = {wl_g,  16'b0};
    kp[3] = {wl_r,  16'b0};
    kp[4] = {wl_ir, 16'b0};
    kv[0] = (VAL_W'(s1_col[2]) << 2) + (VAL_W'(s1_col[1]) << 1) + VAL_W'(s1_col[0]);
    kv[1] = VAL_W'(s1_col[2]) << 3;
    kv[2] = VAL_W'(s1_col[1]) << 3;
    kv[3] = VAL_W'(s1_col[0]) << 3;
    kv[4] = VAL_W'(s1_col[2]) + (VAL_W'(s1_col[1]) << 1) + (VAL_W'(s1_col[0]) << 2);
    for (int c = 0; c < 3; c++) begin
      if (s1_unit) begin
        sel[c] = mk_byp(s1_col[c]);
      end else if (s1_mode) begin
        // flat wings
        if (s1_p[c] < POS_W'(kp[1]))      sel[c] = mk_byp(s1_col[2]);
        else if (s1_p[c] < POS_W'(kp[2])) sel[c] = mk_seg(kv[1], kv[2], s1_p[c], kp[1], kp[2]);
        else if (s1_p[c] < POS_W'(kp[3])) sel[c] = mk_seg(kv[2], kv[3], s1_p[c], kp[2], kp[3]);
        else                              sel[c] = mk_byp(s1_col[0]);
      end else begin
        // falloff spectrum
        if (s1_p[c] < POS_W'(kp[0]))      sel[c] = mk_seg('0, kv[0], s1_p[c], '0, kp[0]);
        else if (s1_p[c] < POS_W'(kp[1])) sel[c] = mk_seg(kv[0], kv[1], s1_p[c], kp[0], kp[1]);
        else if (s1_p[c] < POS_W'(kp[2])) sel[c] = mk_seg(kv[1], kv[2], s1_p[c], kp[1], kp[2]);
        else if (s1_p[c] < POS_W'(kp[3])) sel[c] = mk_seg(kv[2], kv[3], s1_p[c], kp[2], kp[3]);
        else if (s1_p[c] < POS_W'(kp[4])) sel[c] = mk_seg(kv[3], kv[4], s1_p[c], kp[3], kp[4]);
        else if (s1_p[c] == '0)           sel[c] = mk_byp('0);
        else begin
          // infrared wing: Wir * posIr / p
          sel[c]      = '0;
          sel[c].a8   = kv[4];
          sel[c].m1   = kp[4];
          sel[c].d    = s1_p[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) s2[c] <= sel[c];
    end
  end

  // stage 3: interpolation products
  logic [PRD_W-1:0] s3_pa   [3];
  logic [PRD_W-1:0] s3_pb   [3];
  logic [POS_W-1:0] s3_d    [3];
  logic             s3_byp  [3];
  logic [COL_W-1:0] s3_bval [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s3_pa[c]   <= PRD_W'(s2[c].a8) * PRD_W'(s2[c].m1);
        s3_pb[c]   <= PRD_W'(s2[c].b8) * PRD_W'(s2[c].m2);
        s3_d[c]    <= s2[c].d;
        s3_byp[c]  <= s2[c].byp;
        s3_bval[c] <= s2[c].bval;
      end
    end
  end

  // stage 4: dividend with rounding term, divisor 8d
  logic [NUM_W-1:0] s4_n    [3];
  logic [DEN_W-1:0] s4_d    [3];
  logic             s4_byp  [3];
  logic [COL_W-1:0] s4_bval [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s4_n[c]    <= NUM_W'(s3_pa[c]) + NUM_W'(s3_pb[c]) + (NUM_W'(s3_d[c]) << 2);
        s4_d[c]    <= DEN_W'(s3_d[c]) << 3;
        s4_byp[c]  <= s3_byp[c];
        s4_bval[c] <= s3_bval[c];
      end
    end
  end

  // divider per channel
  logic [COL_W-1:0] res [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    dcs_div u_div (
      .clk    (clk),
      .en     (en),
      .num    (s4_n[c]),
      .den    (s4_d[c]),
      .byp    (s4_byp[c]),
      .bval   (s4_bval[c]),
      .result (res[c])
    );
  end

  assign out_ch.valid        = vld[NSTG-1];
  assign out_ch.red_out      = res[0];
  assign out_ch.green_out    = res[1];
  assign out_ch.blue_out     = res[2];
  assign out_ch.filter_out   = ft_pipe[NSTG-1][2*COL_W-1:COL_W];
  assign out_ch.transmit_out = ft_pipe[NSTG-1][COL_W-1:0];

`ifndef SYNTHESIS
  // a stalled result stays on the output
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped during stall");

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> vld[0])
    else $error("accepted request lost");

  // nothing in flight after reset
  a_rst: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipe not empty after reset");

  // the pipe only freezes with a full output
  a_frz: assert property (@(posedge clk) disable iff (rst)
    !en |-> (out_ch.valid && !out_ch.ready))
    else $error("pipe stalled without cause");
`endif

endmodule

### hw/rtl/dcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_div
// Pipelined restoring divider, one quotient bit per stage, saturated or bypass output.
// ----------------------------------------------------------------------------
module dcs_div
  import dcs_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             byp,
  input  logic [COL_W-1:0] bval,
  output logic [COL_W-1:0] result
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] d;
    logic [QB-1:0]    q;
    logic             byp;
    logic [COL_W-1:0] bval;
  } dstage_t;

  dstage_t st [QB];

  // one restoring step at quotient bit sh
  function automatic dstage_t div_step(dstage_t s, int sh);
    logic [REM_W-1:0] dsh;
    dstage_t          o;
    dsh = REM_W'(s.d) << sh;
    o   = s;
    if (s.rem >= dsh) begin
      o.rem   = s.rem - dsh;
      o.q[sh] = 1'b1;
    end
    return o;
  endfunction

  dstage_t head;

  always_comb begin
    head.rem  = REM_W'(num);
    head.d    = den;
    head.q    = '0;
    head.byp  = byp;
    head.bval = bval;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(head, QB - 1);
      for (int k = 1; k < QB; k++) begin
        st[k] <= div_step(st[k-1], QB - 1 - k);
      end
      if (st[QB-1].byp) begin
        result <= st[QB-1].bval;
      end else if (st[QB-1].q[QB-1:COL_W] != '0) begin
        result <= MAX_COL;
      end else begin
        result <= st[QB-1].q[COL_W-1:0];
      end
    end
  end

endmodule
